/* design/mscr_pkg.sv */
// Shared types and constants for the magic-sync CRC frame receiver.
// No dependencies; every other file of the block imports this package.
package mscr_pkg;

    localparam int MAGIC_BYTES_DEF = 4;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_PATTERN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_LENGTH  = 2'd1;

    localparam logic [2:0]  MAGIC_LENGTH_RST = 3'd4;
    localparam logic [15:0] CRC_POLY         = 16'h1021;

    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD  = 2'd1;
    localparam logic [1:0] KIND_FRAME_OK = 2'd2;
    localparam logic [1:0] KIND_CRC_BAD  = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic [15:0] frame_length;
    } rslt_t;

endpackage

/* design/mscr_crc16.sv */
// One-byte CRC-16/XMODEM update (polynomial 0x1021, MSB first), purely combinational.
// Depends on mscr_pkg for the polynomial.
module mscr_crc16
    import mscr_pkg::*;
(
    input  logic [15:0] crc,
    input  logic [7:0]  data,
    output logic [15:0] crc_out
);

    always_comb
    begin
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule

/* design/mscr_parser.sv */
// Frame parser: configuration registers, phase state and the result for each byte.
// Depends on mscr_pkg and instantiates mscr_crc16.
module mscr_parser
    import mscr_pkg::*;
#(
    parameter int MAGIC_BYTES = MAGIC_BYTES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   step,
    input  logic [7:0]             rx_byte,
    output rslt_t                  rslt
);

    // The pattern register holds at most four sync bytes.
    localparam int SYNC_CAP_I = (MAGIC_BYTES > 4) ? 4 : ((MAGIC_BYTES < 1) ? 1 : MAGIC_BYTES);
    localparam logic [2:0] SYNC_CAP = 3'(SYNC_CAP_I);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN,
        PH_DATA,
        PH_CRC
    } phase_t;

    logic [31:0] magic_pattern_reg;
    logic [2:0]  magic_length_reg;

    phase_t      phase_reg, phase_next;
    logic [2:0]  magic_count_reg, magic_count_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] byte_count_reg, byte_count_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_high_reg, crc_high_next;

    logic [15:0] crc_upd;
    logic [2:0]  sync_len;
    logic [7:0]  expect_byte;
    logic [31:0] pattern_shifted;
    logic [15:0] count_inc;

    mscr_crc16 u_crc
    (
        .crc     (crc_reg),
        .data    (rx_byte),
        .crc_out (crc_upd)
    );

    always_comb
    begin
        sync_len = magic_length_reg;
        if (sync_len == 3'd0)
        begin
            sync_len = 3'd1;
        end
        if (sync_len > SYNC_CAP)
        begin
            sync_len = SYNC_CAP;
        end
    end

    // Sync byte k sits at bits [31-8k : 24-8k]; 3-k is the bitwise inverse of k.
    assign pattern_shifted = magic_pattern_reg >> {~magic_count_reg[1:0], 3'b000};
    assign expect_byte     = pattern_shifted[7:0];
    assign count_inc       = byte_count_reg + 16'd1;

    always_comb
    begin
        phase_next       = phase_reg;
        magic_count_next = magic_count_reg;
        length_next      = length_reg;
        byte_count_next  = byte_count_reg;
        crc_next         = crc_reg;
        crc_high_next    = crc_high_reg;
        rslt             = '{kind: KIND_NONE, payload_byte: 8'd0,
                             byte_index: 16'd0, frame_length: 16'd0};
        unique case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == expect_byte)
                begin
                    magic_count_next = magic_count_reg + 3'd1;
                end
                else
                begin
                    magic_count_next = 3'd0;
                end
                if (magic_count_next >= sync_len)
                begin
                    phase_next      = PH_LEN;
                    byte_count_next = 16'd0;
                    crc_next        = 16'd0;
                end
            end
            PH_LEN:
            begin
                if (byte_count_reg == 16'd0)
                begin
                    length_next     = {rx_byte, 8'd0};
                    byte_count_next = 16'd1;
                end
                else
                begin
                    length_next     = {length_reg[15:8], length_reg[7:0] | rx_byte};
                    byte_count_next = 16'd0;
                    phase_next      = (length_next == 16'd0) ? PH_CRC : PH_DATA;
                end
            end
            PH_DATA:
            begin
                rslt.kind         = KIND_PAYLOAD;
                rslt.payload_byte = rx_byte;
                rslt.byte_index   = byte_count_reg;
                rslt.frame_length = length_reg;
                crc_next          = crc_upd;
                byte_count_next   = count_inc;
                if (count_inc >= length_reg)
                begin
                    byte_count_next = 16'd0;
                    phase_next      = PH_CRC;
                end
            end
            PH_CRC:
            begin
                if (byte_count_reg == 16'd0)
                begin
                    crc_high_next   = rx_byte;
                    byte_count_next = 16'd1;
                end
                else
                begin
                    rslt.kind = ({crc_high_reg, rx_byte} == crc_reg) ? KIND_FRAME_OK
                                                                      : KIND_CRC_BAD;
                    rslt.frame_length = length_reg;
                    byte_count_next   = 16'd0;
                    magic_count_next  = 3'd0;
                    phase_next        = PH_HUNT;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_pattern_reg <= 32'd0;
            magic_length_reg  <= MAGIC_LENGTH_RST;
            phase_reg         <= PH_HUNT;
            magic_count_reg   <= 3'd0;
            length_reg        <= 16'd0;
            byte_count_reg    <= 16'd0;
            crc_reg           <= 16'd0;
            crc_high_reg      <= 8'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MAGIC_PATTERN: magic_pattern_reg <= cfg_data;
                    CFG_MAGIC_LENGTH:  magic_length_reg  <= cfg_data[2:0];
                    default:           ;
                endcase
            end
            if (step)
            begin
                phase_reg       <= phase_next;
                magic_count_reg <= magic_count_next;
                length_reg      <= length_next;
                byte_count_reg  <= byte_count_next;
                crc_reg         <= crc_next;
                crc_high_reg    <= crc_high_next;
            end
        end
    end

    // Leaving the CRC phase always clears the position count.
    a_hunt_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HUNT |-> byte_count_reg == 16'd0)
        else $error("byte count not clear while hunting");

    // A zero length field skips the payload phase entirely.
    a_data_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> length_reg != 16'd0 && byte_count_reg < length_reg)
        else $error("payload position outside frame length");

    a_hdr_count_small: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LEN || phase_reg == PH_CRC) |-> byte_count_reg <= 16'd1)
        else $error("header byte count out of range");

    a_sync_enters_len: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_HUNT && magic_count_next >= sync_len
        |=> phase_reg == PH_LEN && crc_reg == 16'd0)
        else $error("sync match did not start the length phase");

endmodule

/* design/mscr_out_reg.sv */
// Result register with valid/stall handshake towards the consumer.
// Depends on mscr_pkg for the result structure.
module mscr_out_reg
    import mscr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  load,
    input  rslt_t rslt_in,
    input  logic  out_stall,
    output logic  out_valid,
    output logic  full_hold,
    output rslt_t rslt_out
);

    logic  valid_reg, valid_next;
    rslt_t data_reg;

    // The register may be refilled in the same cycle that its transaction completes.
    assign full_hold  = valid_reg && out_stall;
    assign valid_next = load ? 1'b1 : full_hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= rslt_in;
        end
    end

    assign out_valid = valid_reg;
    assign rslt_out  = data_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        full_hold |-> !load)
        else $error("result overwritten while stalled");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        full_hold |=> valid_reg && $stable(data_reg))
        else $error("stalled result changed");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> valid_reg)
        else $error("loaded result not presented");

endmodule

/* design/magic_sync_crc_frame_receiver_top.sv */
// Top level of the magic-sync CRC frame receiver.
// Depends on mscr_pkg; instantiates mscr_parser and mscr_out_reg.
//
// The block takes one received byte per clock cycle and returns exactly one result
// transaction per byte, in the cycle after the byte is taken. Throughput is one byte every
// cycle: the CRC update, sync compare and phase logic all settle between the parser
// state registers and the result register. Input is stalled only while the result
// register holds a transaction that the consumer is stalling. Configuration writes
// take effect at the next clock edge and belong in idle periods.
module magic_sync_crc_frame_receiver_top
    import mscr_pkg::*;
#(
    parameter int MAGIC_BYTES = MAGIC_BYTES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             rx_byte,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             kind,
    output logic [7:0]             payload_byte,
    output logic [15:0]            byte_index,
    output logic [15:0]            frame_length
);

    logic  step;
    logic  full_hold;
    rslt_t rslt_comb;
    rslt_t rslt_q;

    assign in_stall = full_hold;
    assign step     = in_valid && !full_hold;

    mscr_parser #(
        .MAGIC_BYTES (MAGIC_BYTES)
    ) u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .rx_byte   (rx_byte),
        .rslt      (rslt_comb)
    );

    mscr_out_reg u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .rslt_in   (rslt_comb),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .full_hold (full_hold),
        .rslt_out  (rslt_q)
    );

    assign kind         = rslt_q.kind;
    assign payload_byte = rslt_q.payload_byte;
    assign byte_index   = rslt_q.byte_index;
    assign frame_length = rslt_q.frame_length;

endmodule
